### src/lwfgs_pkg.sv
package lwfgs_pkg;

   // Input item and result widths
   localparam int COORD_W     = 9;
   localparam int COLOR_W     = 16;
   localparam int WORD_W      = 16;
   localparam int NPIX_W      = 17;
   localparam int REQ_TDATA_W = 88;

   localparam int DEFAULT_MAX_GLYPH_WIDTH  = 16;
   localparam int DEFAULT_MAX_GLYPH_HEIGHT = 32;

   localparam logic [COORD_W-1:0] PANEL_MAX           = 9'd320;
   localparam logic [COORD_W-1:0] RESET_PANEL_WIDTH   = 9'd135;
   localparam logic [COORD_W-1:0] RESET_PANEL_HEIGHT  = 9'd240;

   // Panel commands
   localparam logic [7:0] CMD_CASET = 8'h2A;
   localparam logic [7:0] CMD_RASET = 8'h2B;
   localparam logic [7:0] CMD_RAMWR = 8'h2C;

   // Header byte positions
   localparam logic [3:0] HDR_CASET_IDX = 4'd0;
   localparam logic [3:0] HDR_RASET_IDX = 4'd5;
   localparam logic [3:0] HDR_RAMWR_IDX = 4'd10;

   typedef enum logic [1:0] {
      OP_FILL_START   = 2'd0,
      OP_FILL_ADVANCE = 2'd1,
      OP_GLYPH_START  = 2'd2,
      OP_GLYPH_ROW    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_FILL  = 2'd1,
      MODE_GLYPH = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      CSR_ROTATION     = 2'd0,
      CSR_PANEL_WIDTH  = 2'd1,
      CSR_PANEL_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLIP,
      ST_SETUP,
      ST_HEADER,
      ST_PIXELS
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic clip;
      logic setup;
      logic emit_header;
      logic emit_pixel;
   } dp_cmd_type;

   typedef struct packed {
      logic go_header;
      logic go_pixels;
      logic slot_free;
      logic header_done;
      logic pixels_done;
   } dp_status_type;

   function automatic logic [WORD_W-1:0] x_offset(input logic [1:0] rot);
      logic [WORD_W-1:0] off;
      unique case (rot)
         2'd0:    off = 16'd52;
         2'd1:    off = 16'd40;
         2'd2:    off = 16'd53;
         default: off = 16'd40;
      endcase
      return off;
   endfunction

   function automatic logic [WORD_W-1:0] y_offset(input logic [1:0] rot);
      logic [WORD_W-1:0] off;
      unique case (rot)
         2'd0:    off = 16'd40;
         2'd1:    off = 16'd53;
         2'd2:    off = 16'd40;
         default: off = 16'd52;
      endcase
      return off;
   endfunction

endpackage

### src/lwfgs_ctrl.sv
module lwfgs_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  lwfgs_pkg::dp_status_type  status,
   output lwfgs_pkg::dp_cmd_type     cmd
);
   import lwfgs_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CLIP;
            end
         end
         ST_CLIP: begin
            cmd.clip = 1'b1;
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            if (status.go_header) begin
               state_in = ST_HEADER;
            end else if (status.go_pixels) begin
               state_in = ST_PIXELS;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_HEADER: begin
            if (status.slot_free) begin
               cmd.emit_header = 1'b1;
               if (status.header_done) state_in = ST_IDLE;
            end
         end
         ST_PIXELS: begin
            if (status.slot_free) begin
               cmd.emit_pixel = 1'b1;
               if (status.pixels_done) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### src/lwfgs_datapath.sv
module lwfgs_datapath #(
   parameter int MAX_GLYPH_WIDTH  = lwfgs_pkg::DEFAULT_MAX_GLYPH_WIDTH,
   parameter int MAX_GLYPH_HEIGHT = lwfgs_pkg::DEFAULT_MAX_GLYPH_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [1:0]                          csr_index,
   input  logic [lwfgs_pkg::COORD_W-1:0]       csr_data,
   input  logic [1:0]                          req_tuser,
   input  logic [lwfgs_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [7:0]                          rsp_tdata,
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   input  lwfgs_pkg::dp_cmd_type               cmd,
   output lwfgs_pkg::dp_status_type            status
);
   import lwfgs_pkg::*;

   localparam int COL_W = $clog2(MAX_GLYPH_WIDTH + 1);
   localparam int ROW_W = $clog2(MAX_GLYPH_HEIGHT + 1);
   localparam logic [COORD_W-1:0] MAX_W = COORD_W'(MAX_GLYPH_WIDTH);
   localparam logic [COORD_W-1:0] MAX_H = COORD_W'(MAX_GLYPH_HEIGHT);

   // Configuration
   logic [1:0]         rotation_ff, rotation_in;
   logic [COORD_W-1:0] panel_width_ff, panel_width_in;
   logic [COORD_W-1:0] panel_height_ff, panel_height_in;

   // Captured item
   op_type             op_ff, op_in;
   logic [COORD_W-1:0] x_ff, x_in, y_ff, y_in, w_ff, w_in, h_ff, h_in;
   logic [COLOR_W-1:0] color_ff, color_in, bg_ff, bg_in, bits_ff, bits_in;

   // Clipped window
   logic [COORD_W-1:0] w_eff_ff, w_eff_in, h_eff_ff, h_eff_in;
   logic               on_panel_ff, on_panel_in;

   // Drawing state
   mode_type           mode_ff, mode_in;
   logic [NPIX_W-1:0]  pixels_left_ff, pixels_left_in;
   logic [COLOR_W-1:0] fill_colour_ff, fill_colour_in;
   logic [COLOR_W-1:0] glyph_fg_ff, glyph_fg_in, glyph_bg_ff, glyph_bg_in;
   logic [COL_W-1:0]   glyph_cols_ff, glyph_cols_in;
   logic [ROW_W-1:0]   rows_left_ff, rows_left_in;

   // Header sequencer
   logic [WORD_W-1:0]  x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in;
   logic               hdr_rel_ff, hdr_rel_in;
   logic [3:0]         hdr_idx_ff, hdr_idx_in;

   // Pixel sequencer
   logic [COLOR_W-1:0] pix_fg_ff, pix_fg_in, pix_bg_ff, pix_bg_in;
   logic [COLOR_W-1:0] row_sh_ff, row_sh_in;
   logic [COL_W-1:0]   pix_left_ff, pix_left_in;
   logic               half_ff, half_in;
   logic               pix_rel_ff, pix_rel_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic               rsp_data_ff, rsp_data_in;
   logic               rsp_rel_ff, rsp_rel_in;
   logic               rsp_last_ff, rsp_last_in;

   // Combinational helpers
   logic [COORD_W:0]   x_end, y_end;
   logic [COORD_W-1:0] w_clip, h_clip, w_sat, h_sat;
   logic [2*COORD_W-1:0] product;
   logic               empty, fill_ok, glyph_ok, final_byte;
   logic [WORD_W-1:0]  xo, yo;
   logic [COLOR_W-1:0] pix_colour;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = {rsp_rel_ff, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      // configuration writes
      rotation_in     = rotation_ff;
      panel_width_in  = panel_width_ff;
      panel_height_in = panel_height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ROTATION:     rotation_in = csr_data[1:0];
            CSR_PANEL_WIDTH:
               panel_width_in = (csr_data > PANEL_MAX) ? PANEL_MAX : csr_data;
            CSR_PANEL_HEIGHT:
               panel_height_in = (csr_data > PANEL_MAX) ? PANEL_MAX : csr_data;
            default: ;
         endcase
      end

      // item capture
      op_in    = op_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      color_in = color_ff;
      bg_in    = bg_ff;
      bits_in  = bits_ff;
      if (cmd.load) begin
         op_in    = op_type'(req_tuser);
         x_in     = req_tdata[8:0];
         y_in     = req_tdata[17:9];
         w_in     = req_tdata[26:18];
         h_in     = req_tdata[35:27];
         color_in = req_tdata[51:36];
         bg_in    = req_tdata[67:52];
         bits_in  = req_tdata[83:68];
      end

      // clipping: x + w > width is the same as a last column past the edge
      x_end  = {1'b0, x_ff} + {1'b0, w_ff};
      y_end  = {1'b0, y_ff} + {1'b0, h_ff};
      w_clip = (x_end > {1'b0, panel_width_ff}) ? panel_width_ff - x_ff : w_ff;
      h_clip = (y_end > {1'b0, panel_height_ff}) ? panel_height_ff - y_ff : h_ff;
      w_sat  = (w_ff > MAX_W) ? MAX_W : w_ff;
      h_sat  = (h_ff > MAX_H) ? MAX_H : h_ff;
      w_eff_in    = w_eff_ff;
      h_eff_in    = h_eff_ff;
      on_panel_in = on_panel_ff;
      if (cmd.clip) begin
         on_panel_in = (x_ff < panel_width_ff) && (y_ff < panel_height_ff);
         w_eff_in    = (op_ff == OP_GLYPH_START) ? w_sat : w_clip;
         h_eff_in    = (op_ff == OP_GLYPH_START) ? h_sat : h_clip;
      end

      // setup
      product  = {{COORD_W{1'b0}}, w_eff_ff} * {{COORD_W{1'b0}}, h_eff_ff};
      empty    = (w_eff_ff == '0) || (h_eff_ff == '0);
      fill_ok  = (mode_ff == MODE_FILL) && (pixels_left_ff != '0);
      glyph_ok = (mode_ff == MODE_GLYPH) && (rows_left_ff != '0) && (glyph_cols_ff != '0);
      xo = x_offset(rotation_ff);
      yo = y_offset(rotation_ff);

      mode_in        = mode_ff;
      pixels_left_in = pixels_left_ff;
      fill_colour_in = fill_colour_ff;
      glyph_fg_in    = glyph_fg_ff;
      glyph_bg_in    = glyph_bg_ff;
      glyph_cols_in  = glyph_cols_ff;
      rows_left_in   = rows_left_ff;
      x0_in      = x0_ff;
      x1_in      = x1_ff;
      y0_in      = y0_ff;
      y1_in      = y1_ff;
      hdr_rel_in = hdr_rel_ff;
      hdr_idx_in = hdr_idx_ff;
      pix_fg_in   = pix_fg_ff;
      pix_bg_in   = pix_bg_ff;
      row_sh_in   = row_sh_ff;
      pix_left_in = pix_left_ff;
      half_in     = half_ff;
      pix_rel_in  = pix_rel_ff;

      if (cmd.setup) begin
         x0_in = {7'd0, x_ff} + xo;
         x1_in = {7'd0, x_ff} + {7'd0, w_eff_ff} - 16'd1 + xo;
         y0_in = {7'd0, y_ff} + yo;
         y1_in = {7'd0, y_ff} + {7'd0, h_eff_ff} - 16'd1 + yo;
         hdr_rel_in = empty;
         hdr_idx_in = HDR_CASET_IDX;
         half_in    = 1'b0;
         case (op_ff)
            OP_FILL_START: begin
               if (on_panel_ff) begin
                  fill_colour_in = color_ff;
                  pixels_left_in = product[NPIX_W-1:0];
                  mode_in        = empty ? MODE_IDLE : MODE_FILL;
               end
            end
            OP_FILL_ADVANCE: begin
               if (fill_ok) begin
                  pixels_left_in = pixels_left_ff - NPIX_W'(1);
                  if (pixels_left_ff == NPIX_W'(1)) mode_in = MODE_IDLE;
                  pix_fg_in   = fill_colour_ff;
                  pix_bg_in   = fill_colour_ff;
                  row_sh_in   = '1;
                  pix_left_in = COL_W'(1);
                  pix_rel_in  = (pixels_left_ff == NPIX_W'(1));
               end
            end
            OP_GLYPH_START: begin
               glyph_fg_in   = color_ff;
               glyph_bg_in   = bg_ff;
               glyph_cols_in = w_eff_ff[COL_W-1:0];
               rows_left_in  = h_eff_ff[ROW_W-1:0];
               mode_in       = empty ? MODE_IDLE : MODE_GLYPH;
            end
            default: begin
               if (glyph_ok) begin
                  rows_left_in = rows_left_ff - ROW_W'(1);
                  if (rows_left_ff == ROW_W'(1)) mode_in = MODE_IDLE;
                  pix_fg_in   = glyph_fg_ff;
                  pix_bg_in   = glyph_bg_ff;
                  row_sh_in   = bits_ff;
                  pix_left_in = glyph_cols_ff;
                  pix_rel_in  = (rows_left_ff == ROW_W'(1));
               end
            end
         endcase
      end

      status.go_header   = ((op_ff == OP_FILL_START) && on_panel_ff) ||
                           (op_ff == OP_GLYPH_START);
      status.go_pixels   = ((op_ff == OP_FILL_ADVANCE) && fill_ok) ||
                           ((op_ff == OP_GLYPH_ROW) && glyph_ok);
      status.slot_free   = !rsp_valid_ff || rsp_tready;
      status.header_done = (hdr_idx_ff == HDR_RAMWR_IDX);
      status.pixels_done = half_ff && (pix_left_ff == COL_W'(1));

      // output register
      pix_colour = row_sh_ff[COLOR_W-1] ? pix_fg_ff : pix_bg_ff;
      final_byte = half_ff && (pix_left_ff == COL_W'(1));
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_rel_in   = rsp_rel_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;

      if (cmd.emit_header) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = 1'b1;
         rsp_rel_in   = 1'b0;
         rsp_last_in  = 1'b0;
         hdr_idx_in   = hdr_idx_ff + 4'd1;
         unique case (hdr_idx_ff)
            HDR_CASET_IDX: begin
               rsp_byte_in = CMD_CASET;
               rsp_data_in = 1'b0;
            end
            4'd1: rsp_byte_in = x0_ff[15:8];
            4'd2: rsp_byte_in = x0_ff[7:0];
            4'd3: rsp_byte_in = x1_ff[15:8];
            4'd4: rsp_byte_in = x1_ff[7:0];
            HDR_RASET_IDX: begin
               rsp_byte_in = CMD_RASET;
               rsp_data_in = 1'b0;
            end
            4'd6: rsp_byte_in = y0_ff[15:8];
            4'd7: rsp_byte_in = y0_ff[7:0];
            4'd8: rsp_byte_in = y1_ff[15:8];
            4'd9: rsp_byte_in = y1_ff[7:0];
            HDR_RAMWR_IDX: begin
               rsp_byte_in = CMD_RAMWR;
               rsp_data_in = 1'b0;
               rsp_rel_in  = hdr_rel_ff;
               rsp_last_in = 1'b1;
            end
            default: rsp_byte_in = 8'd0;
         endcase
      end

      if (cmd.emit_pixel) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = half_ff ? pix_colour[7:0] : pix_colour[15:8];
         rsp_data_in  = 1'b1;
         rsp_rel_in   = final_byte && pix_rel_ff;
         rsp_last_in  = final_byte;
         half_in      = !half_ff;
         if (half_ff) begin
            row_sh_in   = {row_sh_ff[COLOR_W-2:0], 1'b0};
            pix_left_in = pix_left_ff - COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff     <= 2'd0;
         panel_width_ff  <= RESET_PANEL_WIDTH;
         panel_height_ff <= RESET_PANEL_HEIGHT;
         mode_ff         <= MODE_IDLE;
         pixels_left_ff  <= '0;
         fill_colour_ff  <= '0;
         glyph_fg_ff     <= '0;
         glyph_bg_ff     <= '0;
         glyph_cols_ff   <= '0;
         rows_left_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rotation_ff     <= rotation_in;
         panel_width_ff  <= panel_width_in;
         panel_height_ff <= panel_height_in;
         mode_ff         <= mode_in;
         pixels_left_ff  <= pixels_left_in;
         fill_colour_ff  <= fill_colour_in;
         glyph_fg_ff     <= glyph_fg_in;
         glyph_bg_ff     <= glyph_bg_in;
         glyph_cols_ff   <= glyph_cols_in;
         rows_left_ff    <= rows_left_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      color_ff    <= color_in;
      bg_ff       <= bg_in;
      bits_ff     <= bits_in;
      w_eff_ff    <= w_eff_in;
      h_eff_ff    <= h_eff_in;
      on_panel_ff <= on_panel_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y0_ff       <= y0_in;
      y1_ff       <= y1_in;
      hdr_rel_ff  <= hdr_rel_in;
      hdr_idx_ff  <= hdr_idx_in;
      pix_fg_ff   <= pix_fg_in;
      pix_bg_ff   <= pix_bg_in;
      row_sh_ff   <= row_sh_in;
      pix_left_ff <= pix_left_in;
      half_ff     <= half_in;
      pix_rel_ff  <= pix_rel_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_data_ff <= rsp_data_in;
      rsp_rel_ff  <= rsp_rel_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

### src/lcd_window_fill_glyph_streamer.sv
// Drawing requests in, panel link bytes out.
// req channel: one transfer per drawing request; tuser carries the opcode
// (fill start, fill advance, glyph start, glyph row), tdata the window,
// colors and glyph row bits.
// rsp channel: one byte per transfer; tuser flags data vs. command and the
// chip-select release point, tlast marks the final byte caused by a request.
// csr channel: register writes (rotation, panel width, panel height), always
// ready; width and height above 320 saturate to 320. Write only when idle.
// Timing: a request is taken, clipped and then set up (one 9x9 multiply);
// the item, the clipped window and the header words are registered in turn
// before the first byte reaches the output register. Bytes then leave at
// one per cycle while rsp_tready is high. A window header is 11 bytes, a
// fill pixel 2, a glyph row 2*cols (32 at 16 columns); some requests
// produce no bytes at all.
// req_tready is high only between requests. A stalled rsp_tready holds the
// byte in the output register and freezes the sequencer; the last byte of a
// request may still wait there while the next request is taken.
// Reset clears the drawing state to idle and restores the register defaults
// (rotation 0, 135 x 240).
module lcd_window_fill_glyph_streamer #(
   parameter int MAX_GLYPH_WIDTH  = lwfgs_pkg::DEFAULT_MAX_GLYPH_WIDTH,
   parameter int MAX_GLYPH_HEIGHT = lwfgs_pkg::DEFAULT_MAX_GLYPH_HEIGHT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // x, y, width, height, color, bg_color, row_bits, zero pad
   input  logic [lwfgs_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // op
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // link_byte
   output logic [7:0]                         rsp_tdata,
   // is_data, cs_release
   output logic [1:0]                         rsp_tuser,
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [1:0]                         csr_index,
   input  logic [lwfgs_pkg::COORD_W-1:0]      csr_data
);
   import lwfgs_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   assign csr_ready = 1'b1;

   lwfgs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   lwfgs_datapath #(
      .MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
      .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (dp_cmd),
      .status     (dp_status)
   );

`ifndef SYNTH
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({dp_cmd.load, dp_cmd.clip, dp_cmd.setup, dp_cmd.emit_header,
                dp_cmd.emit_pixel}))
      else $error("more than one datapath command at once");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.emit_header || dp_cmd.emit_pixel) |-> dp_status.slot_free)
      else $error("byte emitted over an untaken output");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.emit_header || dp_cmd.emit_pixel) |=> rsp_tvalid)
      else $error("emitted byte not presented");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while previous one is in work");
`endif

endmodule
